// File: hw/rtl/voxel_rotate_place_bound_top_macros.svh
// ---------------------------------------------------------------------------
// Voxel rotate/place/bound assertion macros
// Concurrent assertion helpers; they compile away when SYNTHESIS is set.
// ---------------------------------------------------------------------------
`ifndef VOXEL_ROTATE_PLACE_BOUND_TOP_MACROS_SVH
`define VOXEL_ROTATE_PLACE_BOUND_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define VRPB_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vrpb assertion failed");
// next-cycle implication
`define VRPB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vrpb assertion failed");
`else
`define VRPB_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define VRPB_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: hw/rtl/vrpb_pkg.sv
// ---------------------------------------------------------------------------
// Voxel rotate/place/bound package
// Shared types, register indexes and reset values.
// ---------------------------------------------------------------------------
package vrpb_pkg;

   typedef logic signed [16:0] coord_type;

   // register indexes on the csr port
   localparam logic [2:0] REG_ROTATION_CODE  = 3'd0;
   localparam logic [2:0] REG_OFFSET_X       = 3'd1;
   localparam logic [2:0] REG_OFFSET_Y       = 3'd2;
   localparam logic [2:0] REG_OFFSET_Z       = 3'd3;
   localparam logic [2:0] REG_EXTENT_X       = 3'd4;
   localparam logic [2:0] REG_EXTENT_Y       = 3'd5;
   localparam logic [2:0] REG_EXTENT_Z       = 3'd6;
   localparam logic [2:0] REG_MATERIAL_COUNT = 3'd7;

   localparam logic [6:0] ROTATION_RESET       = 7'd4;
   localparam logic [8:0] MATERIAL_COUNT_RESET = 9'd256;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [6:0]         rotation_code;
      logic signed [15:0] offset_x;
      logic signed [15:0] offset_y;
      logic signed [15:0] offset_z;
      logic [8:0]         extent_x;
      logic [8:0]         extent_y;
      logic [8:0]         extent_z;
      logic [8:0]         material_count;
   } cfg_type;

   // one placed voxel waiting for the bounding-box stage
   typedef struct packed {
      coord_type  eng_x;
      coord_type  eng_y;
      coord_type  eng_z;
      logic [7:0] material;
      logic       bad_material;
      logic       restart;
   } entry_type;

   function automatic coord_type axis_select(input logic [1:0] col,
                                             input coord_type l0,
                                             input coord_type l1,
                                             input coord_type l2);
      coord_type r;
      case (col)
         2'd0:    r = l0;
         2'd1:    r = l1;
         default: r = l2;
      endcase
      return r;
   endfunction

endpackage

// File: hw/rtl/vrpb_front.sv
// ---------------------------------------------------------------------------
// Voxel front end
// Accepts voxels, drops empty ones, centres, rotates, translates, swaps axes.
// ---------------------------------------------------------------------------
module vrpb_front (
   input  logic               clock,
   input  logic               reset,
   input  vrpb_pkg::cfg_type  cfg,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [31:0]        req_tdata,   // vox_x, vox_y, vox_z, colour_index
   input  logic               req_tuser,   // model_start
   input  logic               q_full,
   output logic               q_push,
   output vrpb_pkg::entry_type q_entry
);
   import vrpb_pkg::*;

   logic [7:0] vox_x, vox_y, vox_z, colour_index;
   logic       accepted, empty_vox;
   logic       restart_pend_ff, restart_pend_in;
   coord_type  local_x, local_y, local_z;
   logic [1:0] col0, col1, col2;
   logic       neg0, neg1, neg2, malformed;
   coord_type  row0, row1, row2;
   coord_type  scene0, scene1, scene2;

   assign vox_x        = req_tdata[7:0];
   assign vox_y        = req_tdata[15:8];
   assign vox_z        = req_tdata[23:16];
   assign colour_index = req_tdata[31:24];

   assign req_tready = !q_full;
   assign accepted   = req_tvalid && req_tready;
   assign empty_vox  = (colour_index == 8'd0);
   assign q_push     = accepted && !empty_vox;

   // centre on pivot = extent / 2
   assign local_x = coord_type'({9'd0, vox_x} - {9'd0, cfg.extent_x[8:1]});
   assign local_y = coord_type'({9'd0, vox_y} - {9'd0, cfg.extent_y[8:1]});
   assign local_z = coord_type'({9'd0, vox_z} - {9'd0, cfg.extent_z[8:1]});

   // signed permutation decode; bad codes fall back to identity
   always_comb begin
      malformed = (cfg.rotation_code[1:0] == 2'd3) || (cfg.rotation_code[3:2] == 2'd3)
               || (cfg.rotation_code[1:0] == cfg.rotation_code[3:2]);
      if (malformed) begin
         col0 = 2'd0;
         col1 = 2'd1;
         col2 = 2'd2;
         neg0 = 1'b0;
         neg1 = 1'b0;
         neg2 = 1'b0;
      end else begin
         col0 = cfg.rotation_code[1:0];
         col1 = cfg.rotation_code[3:2];
         col2 = 2'd3 - cfg.rotation_code[1:0] - cfg.rotation_code[3:2];
         neg0 = cfg.rotation_code[4];
         neg1 = cfg.rotation_code[5];
         neg2 = cfg.rotation_code[6];
      end
   end

   assign row0 = axis_select(col0, local_x, local_y, local_z);
   assign row1 = axis_select(col1, local_x, local_y, local_z);
   assign row2 = axis_select(col2, local_x, local_y, local_z);

   assign scene0 = (neg0 ? -row0 : row0) + coord_type'(cfg.offset_x);
   assign scene1 = (neg1 ? -row1 : row1) + coord_type'(cfg.offset_y);
   assign scene2 = (neg2 ? -row2 : row2) + coord_type'(cfg.offset_z);

   // Z-up to Y-up
   assign q_entry.eng_x        = scene0;
   assign q_entry.eng_y        = scene2;
   assign q_entry.eng_z        = -scene1;
   assign q_entry.material     = colour_index;
   assign q_entry.bad_material = ({1'b0, colour_index} >= cfg.material_count);
   assign q_entry.restart      = req_tuser || restart_pend_ff;

   // a model start on an empty voxel carries over to the next placed one
   always_comb begin
      restart_pend_in = restart_pend_ff;
      if (accepted) begin
         restart_pend_in = empty_vox ? (restart_pend_ff || req_tuser) : 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         restart_pend_ff <= 1'b0;
      end else begin
         restart_pend_ff <= restart_pend_in;
      end
   end

endmodule

// File: hw/rtl/vrpb_queue.sv
// ---------------------------------------------------------------------------
// Voxel queue
// Two-entry register queue between front end and bounding-box stage.
// ---------------------------------------------------------------------------
module vrpb_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_push,
   input  vrpb_pkg::entry_type q_wdata,
   output logic                q_full,
   input  logic                q_pop,
   output logic                q_valid,
   output vrpb_pkg::entry_type q_rdata
);
   import vrpb_pkg::*;

   localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   entry_type          slot_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0]    count_ff;

   assign q_full  = (count_ff == CntW'(QUEUE_DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_rdata = slot_ff[rd_ptr_ff];

   function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
      return (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (q_push) begin
            wr_ptr_ff <= ptr_next(wr_ptr_ff);
         end
         if (q_pop) begin
            rd_ptr_ff <= ptr_next(rd_ptr_ff);
         end
         if (q_push && !q_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (q_pop && !q_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         slot_ff[wr_ptr_ff] <= q_wdata;
      end
   end

endmodule

// File: hw/rtl/vrpb_back.sv
// ---------------------------------------------------------------------------
// Voxel back end
// Running bounding box per model and the result output register.
// ---------------------------------------------------------------------------
`include "voxel_rotate_place_bound_top_macros.svh"

module vrpb_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  vrpb_pkg::entry_type q_entry,
   output logic                q_pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // eng_x, eng_y, eng_z, material, box_min_x/y/z, box_max_x/y/z, zero pad
   output logic [167:0]        rsp_tdata,
   output logic                rsp_tuser    // bad_material
);
   import vrpb_pkg::*;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       box_valid_ff;
   logic       start;
   coord_type  eng_x_ff, eng_y_ff, eng_z_ff;
   logic [7:0] material_ff;
   logic       bad_ff;
   coord_type  low_x_ff, low_y_ff, low_z_ff, high_x_ff, high_y_ff, high_z_ff;
   coord_type  low_x_in, low_y_in, low_z_in, high_x_in, high_y_in, high_z_in;

   assign q_pop        = q_valid && (!rsp_valid_ff || rsp_tready);
   assign rsp_valid_in = q_pop || (rsp_valid_ff && !rsp_tready);
   assign start        = q_entry.restart || !box_valid_ff;

   always_comb begin
      if (start) begin
         low_x_in  = q_entry.eng_x;
         low_y_in  = q_entry.eng_y;
         low_z_in  = q_entry.eng_z;
         high_x_in = q_entry.eng_x;
         high_y_in = q_entry.eng_y;
         high_z_in = q_entry.eng_z;
      end else begin
         low_x_in  = (q_entry.eng_x < low_x_ff)  ? q_entry.eng_x : low_x_ff;
         low_y_in  = (q_entry.eng_y < low_y_ff)  ? q_entry.eng_y : low_y_ff;
         low_z_in  = (q_entry.eng_z < low_z_ff)  ? q_entry.eng_z : low_z_ff;
         high_x_in = (q_entry.eng_x > high_x_ff) ? q_entry.eng_x : high_x_ff;
         high_y_in = (q_entry.eng_y > high_y_ff) ? q_entry.eng_y : high_y_ff;
         high_z_in = (q_entry.eng_z > high_z_ff) ? q_entry.eng_z : high_z_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         box_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (q_pop) begin
            box_valid_ff <= 1'b1;
         end
      end
   end

   // box registers double as the result's box fields
   always_ff @(posedge clock) begin
      if (q_pop) begin
         eng_x_ff    <= q_entry.eng_x;
         eng_y_ff    <= q_entry.eng_y;
         eng_z_ff    <= q_entry.eng_z;
         material_ff <= q_entry.material;
         bad_ff      <= q_entry.bad_material;
         low_x_ff    <= low_x_in;
         low_y_ff    <= low_y_in;
         low_z_ff    <= low_z_in;
         high_x_ff   <= high_x_in;
         high_y_ff   <= high_y_in;
         high_z_ff   <= high_z_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = bad_ff;
   assign rsp_tdata  = {7'd0, high_z_ff, high_y_ff, high_x_ff, low_z_ff, low_y_ff, low_x_ff,
                        material_ff, eng_z_ff, eng_y_ff, eng_x_ff};

   `VRPB_ASSERT_IMPLY(a_box_ordered, clock, reset, rsp_valid_ff, (low_x_ff <= high_x_ff) && (low_y_ff <= high_y_ff) && (low_z_ff <= high_z_ff))
   `VRPB_ASSERT_IMPLY(a_point_in_box, clock, reset, rsp_valid_ff, (low_x_ff <= eng_x_ff) && (eng_x_ff <= high_x_ff) && (low_z_ff <= eng_z_ff) && (eng_z_ff <= high_z_ff))
   `VRPB_ASSERT_NEXT(a_restart_box, clock, reset, q_pop && q_entry.restart, (low_y_ff == eng_y_ff) && (high_y_ff == eng_y_ff) && box_valid_ff)
   `VRPB_ASSERT_IMPLY(a_no_pop_empty, clock, reset, q_pop, q_valid && box_valid_ff == $past(box_valid_ff || q_pop))

endmodule

// File: hw/rtl/voxel_rotate_place_bound_top.sv
// ---------------------------------------------------------------------------
// Voxel rotate/place/bound top level
// Path: an accepted voxel is written into the queue and, once the result
//   register is free or being read, popped into it; that register drives
//   rsp_tvalid. Empty voxels give no rsp transaction.
// Throughput: one transaction per cycle on both sides; a two-entry queue and
//   the result register let either side stall independently.
// Reset: synchronous, active high; registers return to their reset values,
//   the bounding box is marked empty and the queue and output are emptied.
// ---------------------------------------------------------------------------
module voxel_rotate_place_bound_top (
   input  logic         clock,
   input  logic         reset,
   // input voxel stream
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,    // vox_x, vox_y, vox_z, colour_index
   input  logic         req_tuser,    // model_start
   // placed voxel stream
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // eng_x, eng_y, eng_z, material, box_min_x, box_min_y, box_min_z,
   // box_max_x, box_max_y, box_max_z, then 7 zero bits
   output logic [167:0] rsp_tdata,
   output logic         rsp_tuser,    // bad_material
   // register writes
   input  logic         csr_we,
   input  logic [2:0]   csr_addr,
   input  logic [15:0]  csr_wdata
);
   import vrpb_pkg::*;

   cfg_type   cfg_ff;
   logic      q_push, q_full, q_pop, q_valid;
   entry_type q_wdata, q_rdata;

   // Register file. Writes must land only while the datapath is idle; the block
   // does not enforce this, and the front end reads these directly without any shadowing.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rotation_code  <= ROTATION_RESET;
         cfg_ff.offset_x       <= '0;
         cfg_ff.offset_y       <= '0;
         cfg_ff.offset_z       <= '0;
         cfg_ff.extent_x       <= '0;
         cfg_ff.extent_y       <= '0;
         cfg_ff.extent_z       <= '0;
         cfg_ff.material_count <= MATERIAL_COUNT_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_ROTATION_CODE:  cfg_ff.rotation_code  <= csr_wdata[6:0];
            REG_OFFSET_X:       cfg_ff.offset_x       <= csr_wdata;
            REG_OFFSET_Y:       cfg_ff.offset_y       <= csr_wdata;
            REG_OFFSET_Z:       cfg_ff.offset_z       <= csr_wdata;
            REG_EXTENT_X:       cfg_ff.extent_x       <= csr_wdata[8:0];
            REG_EXTENT_Y:       cfg_ff.extent_y       <= csr_wdata[8:0];
            REG_EXTENT_Z:       cfg_ff.extent_z       <= csr_wdata[8:0];
            REG_MATERIAL_COUNT: cfg_ff.material_count <= csr_wdata[8:0];
            default:            cfg_ff                <= cfg_ff;
         endcase
      end
   end

   // Front end: transform in one combinational pass straight into the queue.
   // Empty voxels are dropped here; their model start is carried forward.
   vrpb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (q_wdata)
   );

   // Queue decouples the transform from the box update and output stall.
   vrpb_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_wdata (q_wdata),
      .q_full  (q_full),
      .q_pop   (q_pop),
      .q_valid (q_valid),
      .q_rdata (q_rdata)
   );

   // Back end: min/max update and result register.
   vrpb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_entry    (q_rdata),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// File: bench/tb.sv
// ---------------------------------------------------------------------------
// Voxel rotate/place/bound testbench
// Streams voxels through the block under several register settings and idle
// patterns. Each accepted voxel is run through a local placement model; each
// placed-voxel transaction is checked field by field against the oldest
// prediction. A watchdog ends the run if traffic stops.
// ---------------------------------------------------------------------------
module tb;
   import vrpb_pkg::*;

   localparam int QUIET_LIMIT = 3000;   // cycles with no transaction at all
   localparam int HOLD_CYCLES = 300;    // long receiver hold-off
   localparam int RANDOM_PHASES = 32;
   localparam int PHASE_ITEMS = 60;

   typedef struct packed {
      logic [7:0] x;
      logic [7:0] y;
      logic [7:0] z;
      logic [7:0] colour;
      logic       start;
   } voxel_in_type;

   typedef struct packed {
      coord_type  ex;
      coord_type  ey;
      coord_type  ez;
      logic [7:0] mat;
      logic       bad;
      coord_type  lo_x;
      coord_type  lo_y;
      coord_type  lo_z;
      coord_type  hi_x;
      coord_type  hi_y;
      coord_type  hi_z;
   } placed_voxel_type;

   // DUT ports; the ones the bench drives are known from time zero
   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [31:0]  req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [167:0] rsp_tdata;
   logic         rsp_tuser;
   logic         csr_we = 1'b0;
   logic [2:0]   csr_addr = '0;
   logic [15:0]  csr_wdata = '0;

   // shadow of the register file
   logic [6:0]         rot_code;
   logic signed [15:0] off_x, off_y, off_z;
   logic [8:0]         ext_x, ext_y, ext_z;
   logic [8:0]         mat_count;

   // running box of the current model
   logic box_live;
   int   box_lo[3];
   int   box_hi[3];

   voxel_in_type     pending_voxels[$];
   placed_voxel_type placed_expect[$];

   int   mismatch_count = 0;
   int   quiet_cycles = 0;
   logic req_fire = 1'b0;

   // idle percentages of the current phase
   int tx_idle_pct = 0;
   int rx_stall_pct = 0;

   // long hold-off: bumping hold_req asks the receiver for one
   int hold_req = 0;
   int hold_seen = 0;
   int hold_left = 0;

   voxel_rotate_place_bound_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Placement model: centre on pivot, signed permutation, offset, Z-up to
   // Y-up, then fold into the running box. An empty voxel only clears the box, if it carries a start.
   // -------------------------------------------------------------------------
   task automatic place_voxel(input logic [31:0] data, input logic start);
      int loc[3];
      int scn[3];
      int eng[3];
      int col[3];
      int sgn[3];
      int a, b, c;
      logic [7:0] colour;
      placed_voxel_type pv;
      colour = data[31:24];
      if (start)
         box_live = 1'b0;
      if (colour == 8'd0)
         return;
      loc[0] = int'(data[7:0]) - int'(ext_x >> 1);
      loc[1] = int'(data[15:8]) - int'(ext_y >> 1);
      loc[2] = int'(data[23:16]) - int'(ext_z >> 1);
      a = int'(rot_code[1:0]);
      b = int'(rot_code[3:2]);
      c = 3 - a - b;
      // bad column codes fall back to identity, signs dropped
      if (a > 2 || b > 2 || c < 0 || c > 2 || a == b) begin
         col = '{0, 1, 2};
         sgn = '{1, 1, 1};
      end else begin
         col = '{a, b, c};
         sgn[0] = rot_code[4] ? -1 : 1;
         sgn[1] = rot_code[5] ? -1 : 1;
         sgn[2] = rot_code[6] ? -1 : 1;
      end
      for (int r = 0; r < 3; r++)
         scn[r] = sgn[r] * loc[col[r]];
      scn[0] += int'(off_x);
      scn[1] += int'(off_y);
      scn[2] += int'(off_z);
      eng[0] = scn[0];
      eng[1] = scn[2];
      eng[2] = -scn[1];
      for (int r = 0; r < 3; r++) begin
         if (!box_live || eng[r] < box_lo[r])
            box_lo[r] = eng[r];
         if (!box_live || eng[r] > box_hi[r])
            box_hi[r] = eng[r];
      end
      box_live = 1'b1;
      pv.ex   = eng[0][16:0];
      pv.ey   = eng[1][16:0];
      pv.ez   = eng[2][16:0];
      pv.mat  = colour;
      pv.bad  = ({1'b0, colour} >= mat_count);
      pv.lo_x = box_lo[0][16:0];
      pv.lo_y = box_lo[1][16:0];
      pv.lo_z = box_lo[2][16:0];
      pv.hi_x = box_hi[0][16:0];
      pv.hi_y = box_hi[1][16:0];
      pv.hi_z = box_hi[2][16:0];
      placed_expect.insert(placed_expect.size(), pv);
   endtask

   function automatic void compare_field(input string name, input int want, input int got);
      if (want != got) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mismatch %s: expected %0d, got %0d", name, want, got);
      end
   endfunction

   task automatic check_placed();
      placed_voxel_type pv;
      if (placed_expect.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mismatch: placed voxel with nothing pending, tdata %h", rsp_tdata);
         return;
      end
      pv = placed_expect.pop_front();
      compare_field("eng_x", pv.ex, $signed(rsp_tdata[0 +: 17]));
      compare_field("eng_y", pv.ey, $signed(rsp_tdata[17 +: 17]));
      compare_field("eng_z", pv.ez, $signed(rsp_tdata[34 +: 17]));
      compare_field("material", pv.mat, rsp_tdata[51 +: 8]);
      compare_field("bad_material", pv.bad, rsp_tuser);
      compare_field("box_min_x", pv.lo_x, $signed(rsp_tdata[59 +: 17]));
      compare_field("box_min_y", pv.lo_y, $signed(rsp_tdata[76 +: 17]));
      compare_field("box_min_z", pv.lo_z, $signed(rsp_tdata[93 +: 17]));
      compare_field("box_max_x", pv.hi_x, $signed(rsp_tdata[110 +: 17]));
      compare_field("box_max_y", pv.hi_y, $signed(rsp_tdata[127 +: 17]));
      compare_field("box_max_z", pv.hi_z, $signed(rsp_tdata[144 +: 17]));
      compare_field("pad", 0, rsp_tdata[167:161]);
   endtask

   // -------------------------------------------------------------------------
   // Monitor: both channels sampled at the rising edge
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      req_fire <= !reset && req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready)
         place_voxel(req_tdata, req_tuser);
      if (!reset && rsp_tvalid && rsp_tready)
         check_placed();
   end

   // watchdog: any accepted transaction on either side counts as progress
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Driver: while tvalid is high the item on the bus is pending_voxels[0]
   // -------------------------------------------------------------------------
   always @(negedge clock) begin : drive_req
      logic offer;
      voxel_in_type it;
      if (req_fire)
         void'(pending_voxels.pop_front());
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!(req_tvalid && !req_fire)) begin
         offer = (pending_voxels.size() != 0) && ($urandom_range(99) >= tx_idle_pct);
         req_tvalid <= offer;
         if (offer) begin
            it = pending_voxels[0];
            req_tdata <= {it.colour, it.z, it.y, it.x};
            req_tuser <= it.start;
         end
      end
   end

   // receiver: random stalls, plus a counted hold-off on request
   always @(negedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen = hold_req;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------
   task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      case (idx)
         REG_ROTATION_CODE:  rot_code  = val[6:0];
         REG_OFFSET_X:       off_x     = val;
         REG_OFFSET_Y:       off_y     = val;
         REG_OFFSET_Z:       off_z     = val;
         REG_EXTENT_X:       ext_x     = val[8:0];
         REG_EXTENT_Y:       ext_y     = val[8:0];
         REG_EXTENT_Z:       ext_z     = val[8:0];
         REG_MATERIAL_COUNT: mat_count = val[8:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_config(input logic [6:0] rot, input logic [15:0] ox,
                             input logic [15:0] oy, input logic [15:0] oz,
                             input logic [8:0] ex, input logic [8:0] ey,
                             input logic [8:0] ez, input logic [8:0] cnt);
      write_reg(REG_ROTATION_CODE, {9'd0, rot});
      write_reg(REG_OFFSET_X, ox);
      write_reg(REG_OFFSET_Y, oy);
      write_reg(REG_OFFSET_Z, oz);
      write_reg(REG_EXTENT_X, {7'd0, ex});
      write_reg(REG_EXTENT_Y, {7'd0, ey});
      write_reg(REG_EXTENT_Z, {7'd0, ez});
      write_reg(REG_MATERIAL_COUNT, {7'd0, cnt});
   endtask

   task automatic queue_voxel(input logic [7:0] x, input logic [7:0] y, input logic [7:0] z,
                              input logic [7:0] colour, input logic start);
      voxel_in_type it;
      it = '{x: x, y: y, z: z, colour: colour, start: start};
      pending_voxels.insert(pending_voxels.size(), it);
   endtask

   // Drain before touching registers. Empty voxels leave nothing in the
   // queue, so an extra wait after it empties covers anything still in the pipe.
   task automatic wait_idle();
      while (pending_voxels.size() != 0 || req_tvalid || placed_expect.size() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_offset();
      case ($urandom_range(7))
         0: return 16'h8000;
         1: return 16'h7FFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [8:0] pick_extent();
      case ($urandom_range(7))
         0: return 9'd0;
         1: return 9'd256;
         default: return 9'($urandom_range(0, 256));
      endcase
   endfunction

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(15))
         0: return 8'd0;
         1: return 8'd255;
         2: return 8'd128;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // colour mix: some empties, extremes, and the flag boundary
   function automatic logic [7:0] pick_colour();
      case ($urandom_range(11))
         0: return 8'd0;
         1: return 8'd255;
         2: return 8'd1;
         3: return (mat_count >= 9'd1 && mat_count <= 9'd255) ? mat_count[7:0] : 8'd200;
         4: return (mat_count >= 9'd2 && mat_count <= 9'd256) ? 8'(mat_count - 9'd1) : 8'd100;
         default: return 8'($urandom_range(1, 255));
      endcase
   endfunction

   // mostly proper signed permutations, sometimes any code
   function automatic logic [6:0] pick_rotation();
      int a, b;
      if ($urandom_range(3) == 0)
         return 7'($urandom_range(0, 127));
      a = $urandom_range(0, 2);
      b = (a + $urandom_range(1, 2)) % 3;
      return {3'($urandom_range(0, 7)), 2'(b), 2'(a)};
   endfunction

   // models of random length, each opened by model_start, with stray starts
   task automatic queue_models(input int count);
      int done, len;
      done = 0;
      while (done < count) begin
         len = $urandom_range(1, 20);
         for (int i = 0; i < len && done < count; i++) begin
            queue_voxel(pick_byte(), pick_byte(), pick_byte(), pick_colour(),
                        (i == 0) || ($urandom_range(29) == 0));
            done++;
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Test sequence
   // -------------------------------------------------------------------------
   initial begin
      rot_code  = ROTATION_RESET;
      off_x     = '0;
      off_y     = '0;
      off_z     = '0;
      ext_x     = '0;
      ext_y     = '0;
      ext_z     = '0;
      mat_count = MATERIAL_COUNT_RESET;
      box_live  = 1'b0;
      box_lo    = '{0, 0, 0};
      box_hi    = '{0, 0, 0};

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: identity rotation, no offset, pivot at zero
      queue_voxel(8'd0, 8'd0, 8'd0, 8'd1, 1'b1);
      queue_voxel(8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
      queue_voxel(8'd0, 8'd255, 8'd128, 8'd0, 1'b0);
      queue_voxel(8'd128, 8'd0, 8'd255, 8'd2, 1'b0);
      wait_idle();

      // all three rows negated and permuted, offsets at their limits,
      // full extents, every index flagged
      set_config({3'b111, 2'd1, 2'd2}, 16'h7FFF, 16'h8000, 16'h7FFF,
                 9'd256, 9'd256, 9'd256, 9'd0);
      queue_voxel(8'd0, 8'd0, 8'd0, 8'd1, 1'b1);
      queue_voxel(8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
      queue_voxel(8'd255, 8'd0, 8'd255, 8'd128, 1'b0);
      wait_idle();

      // column above 2 gives identity; count above 256 flags nothing;
      // an empty first voxel still restarts the box
      set_config(7'h7F, 16'h8000, 16'h7FFF, 16'h8000, 9'd0, 9'd1, 9'd255, 9'd511);
      queue_voxel(8'd5, 8'd5, 8'd5, 8'd0, 1'b1);
      queue_voxel(8'd0, 8'd0, 8'd0, 8'd255, 1'b0);
      queue_voxel(8'd255, 8'd255, 8'd255, 8'd1, 1'b0);
      queue_voxel(8'd10, 8'd20, 8'd30, 8'd40, 1'b1);
      queue_voxel(8'd200, 8'd7, 8'd90, 8'd0, 1'b1);
      queue_voxel(8'd3, 8'd250, 8'd60, 8'd9, 1'b0);
      wait_idle();

      // equal columns for rows 0 and 1 give identity, signs ignored
      set_config({3'b111, 2'd1, 2'd1}, 16'd0, 16'd0, 16'd0, 9'd17, 9'd100, 9'd3, 9'd1);
      queue_voxel(8'd255, 8'd0, 8'd0, 8'd1, 1'b1);
      queue_voxel(8'd0, 8'd255, 8'd0, 8'd0, 1'b0);
      queue_voxel(8'd0, 8'd0, 8'd255, 8'd3, 1'b0);
      queue_voxel(8'd77, 8'd88, 8'd99, 8'd1, 1'b0);
      wait_idle();

      // random phases rotating through the idle patterns
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         set_config(pick_rotation(), pick_offset(), pick_offset(), pick_offset(),
                    pick_extent(), pick_extent(), pick_extent(),
                    ($urandom_range(7) == 0) ? 9'd0 :
                    ($urandom_range(6) == 0) ? 9'd256 : 9'($urandom_range(1, 255)));
         case (p % 4)
            0: begin
               tx_idle_pct  = 0;
               rx_stall_pct = 0;
            end
            1: begin
               tx_idle_pct  = 63;
               rx_stall_pct = 0;
            end
            2: begin
               tx_idle_pct  = 0;
               rx_stall_pct = 63;
            end
            default: begin
               tx_idle_pct  = 17;
               rx_stall_pct = 17;
            end
         endcase
         // back-pressure: receiver holds off while the sender keeps offering
         if (p == 0 || p == 17)
            hold_req++;
         queue_models(PHASE_ITEMS);
         wait_idle();
      end

      tx_idle_pct  = 0;
      rx_stall_pct = 0;
      wait_idle();
      if (mismatch_count == 0 && placed_expect.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// File: voxel_rotate_place_bound_top.f
+incdir+hw/rtl
hw/rtl/vrpb_pkg.sv
hw/rtl/vrpb_front.sv
hw/rtl/vrpb_queue.sv
hw/rtl/vrpb_back.sv
hw/rtl/voxel_rotate_place_bound_top.sv
bench/tb.sv
